@@ hw/rtl/nnis_pkg.sv @@
package nnis_pkg;

   // fixed field widths
   localparam int PIXEL_W     = 24;
   localparam int SCALE_W     = 14;
   localparam int WIDTH_REG_W = 12;
   localparam int CSR_DATA_W  = 14;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_SCALE = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [SCALE_W-1:0]     SCALE_RESET = 14'd256;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd2048;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_VADD,
      S_STEP,
      S_EMIT
   } state_type;

endpackage

@@ hw/rtl/nnis_channels.sv @@
interface nnis_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [nnis_pkg::PIXEL_W-1:0] pixel_in;

   modport source (output valid, output kind, output pixel_in, input ready);
   modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface nnis_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nnis_pkg::PIXEL_W-1:0] pixel_out;
   logic                         has_pixel;
   logic                         row_end;
   logic                         rejected;
   logic                         last;

   modport source (output valid, output pixel_out, output has_pixel, output row_end,
                   output rejected, output last, input ready);
   modport sink   (input valid, input pixel_out, input has_pixel, input row_end,
                   input rejected, input last, output ready);
endinterface

@@ hw/rtl/nearest_neighbor_image_scaler.sv @@
// channel   | direction | payload
// req_chan  | in        | kind, pixel_in
// rsp_chan  | out       | pixel_out, has_pixel, row_end, rejected, last
// csr_*     | in        | csr_write_enable, csr_index, csr_write_data
//
// a source pixel goes through S_STEP, after S_VADD at the start of a row, and
// S_EMIT for each result; a tick in a replay goes through S_STEP and S_EMIT;
// a pixel turned away during a replay goes straight to S_EMIT, and a tick with
// no replay owed is taken with no result. one adder serves both accumulators.
// reset is synchronous; it clears the accumulators, indexes and sequencer,
// the line store is not cleared. req_chan.ready is low while an item is
// worked; a stalled rsp_chan holds the current result.
module nearest_neighbor_image_scaler #(
   parameter int MAX_WIDTH = 2048,
   parameter int FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   nnis_req_if.sink                        req_chan,
   nnis_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  nnis_pkg::csr_index_type         csr_index,
   input  logic [nnis_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int SW  = nnis_pkg::SCALE_W;
   localparam int PW  = nnis_pkg::PIXEL_W;
   localparam int AW  = ((SW > FRAC_BITS) ? SW : FRAC_BITS) + 1;
   localparam int CW  = AW - FRAC_BITS;
   localparam int IW  = $clog2(MAX_WIDTH);
   localparam int MW  = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (nnis_pkg::WIDTH_REG_W > MW) ? nnis_pkg::WIDTH_REG_W : MW;
   localparam logic [AW-1:0] ONE_FX = AW'(1) << FRAC_BITS;

   // configuration
   logic [SW-1:0]                      scale_ff;
   logic [nnis_pkg::WIDTH_REG_W-1:0]   width_ff;

   // sequencer and block state
   nnis_pkg::state_type state_ff, state_in;
   logic [AW-1:0] vacc_ff, vacc_in;
   logic [AW-1:0] hacc_ff, hacc_in;
   logic [IW-1:0] col_ff, col_in;
   logic          row_kept_ff, row_kept_in;
   logic          pending_ff, pending_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [CW-1:0] rem_ff, rem_in;

   // item payload
   logic          kind_ff, kind_in;
   logic [PW-1:0] pix_ff, pix_in;
   logic          has_ff, has_in;
   logic          end_ff, end_in;
   logic          rej_ff, rej_in;

   // line store
   logic [PW-1:0] line_mem [MAX_WIDTH];
   logic [PW-1:0] rdata_ff;
   logic          mem_we;

   // shared accumulator adder and helpers
   logic [AW-1:0] add_a;
   logic [AW-1:0] add_sum;
   logic [CW-1:0] copies;
   logic [AW-1:0] vfin;
   logic [EW-1:0] eff_w;
   logic          col_over;
   logic          col_start;
   logic [IW-1:0] step_idx;
   logic          step_end;
   logic          step_active;
   logic          req_fire;
   logic          rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // effective row width, clamped to one and to the store depth
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
   end

   assign col_over  = EW'(col_ff) >= eff_w;
   assign col_start = col_over || (col_ff == '0);

   // one adder serves the vertical and the horizontal accumulator
   assign add_a   = (state_ff == nnis_pkg::S_VADD) ? vacc_ff : hacc_ff;
   assign add_sum = add_a + {{(AW-SW){1'b0}}, scale_ff};
   assign copies  = add_sum[AW-1:FRAC_BITS];

   // vertical accumulator after an output row
   assign vfin = (vacc_ff >= ONE_FX) ? (vacc_ff - ONE_FX) : '0;

   assign step_idx    = kind_ff ? ridx_ff : col_ff;
   assign step_end    = ((EW+1)'(step_idx) + (EW+1)'(1)) >= (EW+1)'(eff_w);
   assign step_active = kind_ff || row_kept_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= nnis_pkg::SCALE_RESET;
         width_ff <= nnis_pkg::WIDTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            nnis_pkg::CSR_SCALE: scale_ff <= csr_write_data[SW-1:0];
            nnis_pkg::CSR_WIDTH: width_ff <= csr_write_data[nnis_pkg::WIDTH_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nnis_pkg::S_IDLE: begin
            if (req_fire) begin
               if (!req_chan.kind) begin
                  if (pending_ff) begin
                     state_in = nnis_pkg::S_EMIT;
                  end else if (col_start) begin
                     state_in = nnis_pkg::S_VADD;
                  end else begin
                     state_in = nnis_pkg::S_STEP;
                  end
               end else if (pending_ff) begin
                  state_in = nnis_pkg::S_STEP;
               end
            end
         end
         nnis_pkg::S_VADD: begin
            state_in = nnis_pkg::S_STEP;
         end
         nnis_pkg::S_STEP: begin
            if (step_active && ((copies != '0) || step_end)) begin
               state_in = nnis_pkg::S_EMIT;
            end else begin
               state_in = nnis_pkg::S_IDLE;
            end
         end
         nnis_pkg::S_EMIT: begin
            if (rsp_fire && (rem_ff == CW'(1))) begin
               state_in = nnis_pkg::S_IDLE;
            end
         end
         default: state_in = nnis_pkg::S_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      vacc_in     = vacc_ff;
      hacc_in     = hacc_ff;
      col_in      = col_ff;
      row_kept_in = row_kept_ff;
      pending_in  = pending_ff;
      ridx_in     = ridx_ff;
      rem_in      = rem_ff;
      kind_in     = kind_ff;
      pix_in      = pix_ff;
      has_in      = has_ff;
      end_in      = end_ff;
      rej_in      = rej_ff;
      mem_we      = 1'b0;
      case (state_ff)
         nnis_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_in = req_chan.kind;
               pix_in  = req_chan.pixel_in;
               rej_in  = 1'b0;
               if (!req_chan.kind) begin
                  if (pending_ff) begin
                     // pixel during a replay is dropped
                     rej_in = 1'b1;
                     has_in = 1'b0;
                     end_in = 1'b0;
                     rem_in = CW'(1);
                  end else if (col_over) begin
                     col_in = '0;
                  end
               end
            end
         end
         nnis_pkg::S_VADD: begin
            // start of a source row
            vacc_in     = add_sum;
            row_kept_in = add_sum >= ONE_FX;
            hacc_in     = '0;
         end
         nnis_pkg::S_STEP: begin
            if (!kind_ff) begin
               col_in = step_end ? '0 : IW'(col_ff + 1'b1);
               mem_we = row_kept_ff;
            end
            if (step_active) begin
               hacc_in = {{CW{1'b0}}, add_sum[FRAC_BITS-1:0]};
               pix_in  = kind_ff ? rdata_ff : pix_ff;
               has_in  = copies != '0;
               end_in  = step_end;
               rem_in  = (copies != '0) ? copies : CW'(1);
               if (kind_ff && !step_end) begin
                  ridx_in = IW'(ridx_ff + 1'b1);
               end
               if (step_end) begin
                  // end of an output row
                  vacc_in    = vfin;
                  hacc_in    = '0;
                  ridx_in    = '0;
                  pending_in = vfin >= ONE_FX;
               end
            end
         end
         nnis_pkg::S_EMIT: begin
            if (rsp_fire) begin
               rem_in = rem_ff - CW'(1);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nnis_pkg::S_IDLE;
         vacc_ff     <= '0;
         hacc_ff     <= '0;
         col_ff      <= '0;
         row_kept_ff <= 1'b0;
         pending_ff  <= 1'b0;
         ridx_ff     <= '0;
         rem_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         vacc_ff     <= vacc_in;
         hacc_ff     <= hacc_in;
         col_ff      <= col_in;
         row_kept_ff <= row_kept_in;
         pending_ff  <= pending_in;
         ridx_ff     <= ridx_in;
         rem_ff      <= rem_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pix_ff  <= pix_in;
      has_ff  <= has_in;
      end_ff  <= end_in;
      rej_ff  <= rej_in;
   end

   // line store, registered read at the replay index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[col_ff] <= pix_ff;
      end
      rdata_ff <= line_mem[ridx_ff];
   end

   // handshake and result outputs
   always_comb begin
      req_chan.ready     = state_ff == nnis_pkg::S_IDLE;
      rsp_chan.valid     = state_ff == nnis_pkg::S_EMIT;
      rsp_chan.pixel_out = has_ff ? pix_ff : '0;
      rsp_chan.has_pixel = has_ff;
      rsp_chan.row_end   = end_ff && (rem_ff == CW'(1));
      rsp_chan.rejected  = rej_ff;
      rsp_chan.last      = rem_ff == CW'(1);
   end

endmodule

@@ dv/scaler_tb_pkg.sv @@
`timescale 1ns / 100ps

package scaler_tb_pkg;

   // line store depth and fixed point position of the scaler
   localparam int MAX_WIDTH = 2048;
   localparam int FRAC_BITS = 8;

   // what one request transfer carries
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_TICK  = 1'b1
   } item_kind_type;

endpackage

@@ dv/scaler_checker.sv @@
`timescale 1ns / 100ps

module scaler_checker
   import nnis_pkg::*;
   import scaler_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   nnis_req_if                   req_mon,
   nnis_rsp_if                   rsp_mon,
   input  logic                  csr_write_enable,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int unsigned           mismatch_total,
   output int unsigned           results_owed,
   output logic                  replay_active,
   output int unsigned           stored_len
);

   localparam int unsigned ONE_FX       = 1 << FRAC_BITS;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               has_pixel;
      logic               row_end;
      logic               rejected;
      logic               last;
   } scaled_pixel_type;

   // output pixels still owed by the block, oldest first
   scaled_pixel_type owed_pixels[$];

   // shadow registers and scaler state
   logic [SCALE_W-1:0]     scale_q;
   logic [WIDTH_REG_W-1:0] row_len;
   int unsigned            v_accum;
   int unsigned            h_accum;
   int unsigned            col;
   int unsigned            replay_col;
   logic                   row_kept;
   logic [PIXEL_W-1:0]     line_buf [MAX_WIDTH];

   // row length as the block applies it
   function automatic int unsigned active_width();
      if (row_len == 0) begin
         return 1;
      end
      if (row_len > MAX_WIDTH) begin
         return MAX_WIDTH;
      end
      return row_len;
   endfunction

   task automatic owe(input logic [PIXEL_W-1:0] pix, input logic has, input logic rend,
                      input logic rej, input logic fin);
      owed_pixels.push_back('{pixel_out: pix, has_pixel: has, row_end: rend,
                              rejected: rej, last: fin});
   endtask

   // step the horizontal accumulator and owe the copies of one pixel
   task automatic emit_copies(input logic [PIXEL_W-1:0] pix, input logic end_of_row);
      int unsigned copies;
      h_accum += scale_q;
      copies = h_accum >> FRAC_BITS;
      h_accum &= ONE_FX - 1;
      for (int unsigned i = 0; i < copies; i++) begin
         owe(pix, 1'b1, end_of_row && (i + 1 == copies), 1'b0, i + 1 == copies);
      end
      // a row whose last pixel gets no copy still closes with a marker
      if (copies == 0 && end_of_row) begin
         owe('0, 1'b0, 1'b1, 1'b0, 1'b1);
      end
   endtask

   // end of every kept output row, source or replayed
   task automatic close_row();
      v_accum       = (v_accum >= ONE_FX) ? v_accum - ONE_FX : 0;
      h_accum       = 0;
      replay_col    = 0;
      replay_active = (v_accum >= ONE_FX);
   endtask

   task automatic scale_item(input item_kind_type kind, input logic [PIXEL_W-1:0] pix);
      int unsigned w;
      logic        end_of_row;
      w = active_width();
      if (kind == KIND_PIXEL) begin
         // a source pixel while a replay is owed is turned away
         if (replay_active) begin
            owe('0, 1'b0, 1'b0, 1'b1, 1'b1);
            return;
         end
         if (col >= w) begin
            col = 0;
         end
         if (col == 0) begin
            v_accum += scale_q;
            row_kept = (v_accum >= ONE_FX);
            h_accum  = 0;
         end
         end_of_row = (col + 1 >= w);
         if (row_kept) begin
            line_buf[col] = pix;
            if (col + 1 > stored_len) begin
               stored_len = col + 1;
            end
            emit_copies(pix, end_of_row);
         end
         if (end_of_row) begin
            col = 0;
            if (row_kept) begin
               close_row();
            end
         end else begin
            col++;
         end
      end else if (replay_active) begin
         // one buffered pixel per tick; ticks with no replay owed do nothing
         end_of_row = (replay_col + 1 >= w);
         emit_copies(line_buf[replay_col], end_of_row);
         if (end_of_row) begin
            close_row();
         end else begin
            replay_col++;
         end
      end
   endtask

   task automatic check_result();
      scaled_pixel_type seen;
      scaled_pixel_type want;
      seen = '{pixel_out: rsp_mon.pixel_out, has_pixel: rsp_mon.has_pixel,
               row_end: rsp_mon.row_end, rejected: rsp_mon.rejected, last: rsp_mon.last};
      if (owed_pixels.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT) begin
            $display("%0t: unexpected output transfer pix=%06h has=%b end=%b rej=%b last=%b",
                     $time, seen.pixel_out, seen.has_pixel, seen.row_end, seen.rejected,
                     seen.last);
         end
      end else begin
         want = owed_pixels.pop_front();
         if (seen !== want) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT) begin
               $display("%0t: output mismatch, expected pix=%06h has=%b end=%b rej=%b last=%b",
                        $time, want.pixel_out, want.has_pixel, want.row_end, want.rejected,
                        want.last);
               $display("%0t:                  actual pix=%06h has=%b end=%b rej=%b last=%b",
                        $time, seen.pixel_out, seen.has_pixel, seen.row_end, seen.rejected,
                        seen.last);
            end
         end
      end
   endtask

   // compare output transfers, track register writes, predict input transfers
   always @(posedge clock) begin
      if (reset) begin
         scale_q        = SCALE_RESET;
         row_len        = WIDTH_RESET;
         v_accum        = 0;
         h_accum        = 0;
         col            = 0;
         replay_col     = 0;
         row_kept       = 1'b0;
         replay_active  = 1'b0;
         stored_len     = 0;
         mismatch_total = 0;
         owed_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCALE: scale_q = csr_write_data[SCALE_W-1:0];
               CSR_WIDTH: row_len = csr_write_data[WIDTH_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            scale_item(item_kind_type'(req_mon.kind), req_mon.pixel_in);
         end
      end
      results_owed = owed_pixels.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   import nnis_pkg::*;
   import scaler_tb_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned SETTLE_CYCLES   = 10;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 25;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   nnis_req_if req_chan ();
   nnis_rsp_if rsp_chan ();

   int unsigned mismatch_total;
   int unsigned results_owed;
   logic        replay_active;
   int unsigned stored_len;

   // idling controls for both sides and the watchdog's count of quiet cycles
   bit          calm         = 1'b0;
   int unsigned gap_pct      = 20;
   int unsigned stall_pct    = 20;
   int unsigned hold_asks    = 0;
   int unsigned hold_served  = 0;
   int unsigned quiet_cycles = 0;

   nearest_neighbor_image_scaler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   scaler_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (mismatch_total),
      .results_owed     (results_owed),
      .replay_active    (replay_active),
      .stored_len       (stored_len)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // output side: random stall bursts and the long hold on request
   initial begin : result_sink
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // random idle burst on the input side, otherwise the next item follows at once
   task automatic pause_slot();
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // offer one item and hold it until the transfer; valid stays up for the next one
   task automatic drive_item(input item_kind_type kind, input logic [PIXEL_W-1:0] pix);
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= kind;
      req_chan.pixel_in <= pix;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic offer(input item_kind_type kind, input logic [PIXEL_W-1:0] pix);
      pause_slot();
      drive_item(kind, pix);
   endtask

   // all owed pixels out, then let a resultless item finish
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // a pending replay must not reach past the stored part of the line
   task automatic configure(input int unsigned scale, input int unsigned width);
      settle();
      if (replay_active && width > stored_len) begin
         width = stored_len;
      end
      write_reg(CSR_SCALE, scale);
      write_reg(CSR_WIDTH, width);
   endtask

   // mostly ticks while a replay is owed and pixels otherwise
   task automatic random_phase(input int unsigned n_items);
      int unsigned   sent;
      item_kind_type kind;
      sent = 0;
      while (sent < n_items) begin
         pause_slot();
         if (replay_active) begin
            kind = ($urandom_range(0, 9) != 0) ? KIND_TICK : KIND_PIXEL;
         end else begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_TICK : KIND_PIXEL;
         end
         if (kind == KIND_PIXEL || replay_active) begin
            sent++;
         end
         drive_item(kind, PIXEL_W'($urandom()));
      end
   endtask

   function automatic int unsigned pick_scale();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(1, 255);
         1:       return $urandom_range(256, 767);
         2:       return 256;
         3:       return $urandom_range(768, 2047);
         4:       return $urandom_range(1, 16383);
         default: return ($urandom_range(0, 1) != 0) ? 16383 : 1;
      endcase
   endfunction

   function automatic int unsigned pick_width();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return ($urandom_range(0, 1) != 0) ? 4095 : 2048;
         2, 3:    return $urandom_range(5, 8);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   initial begin : stimulus
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_SCALE;
      csr_write_data       <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= KIND_PIXEL;
      req_chan.pixel_in    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings, row left open
      offer(KIND_PIXEL, 24'h000000);
      offer(KIND_PIXEL, 24'hFFFFFF);
      // oversized width acts as the full line
      configure(256, 4095);
      offer(KIND_PIXEL, 24'h123456);
      // width shrunk below the open column starts a new row
      configure(256, 2);
      offer(KIND_PIXEL, 24'hAAAAAA);
      offer(KIND_PIXEL, 24'h555555);
      // pixel during a pending replay, then the replay itself
      offer(KIND_PIXEL, 24'h0F0F0F);
      offer(KIND_TICK, 24'hFFFFFF);
      offer(KIND_TICK, 24'h000000);
      // tick with nothing to replay
      offer(KIND_TICK, 24'h5A5A5A);
      // fractional upscale with a replayed row
      configure(640, 3);
      offer(KIND_PIXEL, 24'h800001);
      offer(KIND_PIXEL, 24'h7FFFFE);
      offer(KIND_PIXEL, 24'h010203);
      offer(KIND_TICK, 24'h000000);
      offer(KIND_TICK, 24'h000000);
      offer(KIND_TICK, 24'h000000);
      // downscale: dropped row, then a kept row ending with no copy
      configure(64, 2);
      offer(KIND_PIXEL, 24'hC0FFEE);
      offer(KIND_PIXEL, 24'h3F0001);
      offer(KIND_PIXEL, 24'hFEDCBA);
      offer(KIND_PIXEL, 24'h000100);
      // zero scale drops everything
      configure(0, 1);
      offer(KIND_PIXEL, 24'h7F7F7F);
      // largest scale with zero width, leaving a long replay owed
      configure(16383, 0);
      offer(KIND_PIXEL, 24'hE1E2E3);
      offer(KIND_TICK, 24'h000000);

      // random phases, each from an idle block with fresh settings
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         // the long hold phase upscales so that every pixel has results to block on
         configure((phase == 1) ? 640 : pick_scale(), pick_width());
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 40;
         endcase
         // long output hold while items keep coming
         if (phase == 1) begin
            gap_pct = 0;
            hold_asks++;
         end
         if (phase == PHASES - 1) begin
            calm = 1'b1;
         end
         random_phase(ITEMS_PER_PHASE);
      end

      settle();
      if (mismatch_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ nearest_neighbor_image_scaler.f @@
hw/rtl/nnis_pkg.sv
hw/rtl/nnis_channels.sv
hw/rtl/nearest_neighbor_image_scaler.sv
dv/scaler_tb_pkg.sv
dv/scaler_checker.sv
dv/testbench.sv
